[rtl/plce_pkg.sv]
package plce_pkg;

  localparam int KNOT_SLOTS        = 8;
  localparam int DEFAULT_NUM_KNOTS = 8;
  localparam int VAL_W             = 32;
  localparam int KNOT_W            = 2 * VAL_W;
  localparam int DATA_W            = 64;
  localparam int IDX_W             = $clog2(KNOT_SLOTS);
  localparam int ADDR_LSB          = $clog2(DATA_W / 8);
  localparam int ADDR_W            = IDX_W + ADDR_LSB;
  localparam int QUEUE_DEPTH       = 2;

  // One unit of work handed from the classifier to the arithmetic side.
  // For a clamped item y0 already holds the answer.
  typedef struct packed {
    logic             direct;
    logic             neg;
    logic [VAL_W-1:0] y0;
    logic [VAL_W-1:0] dy_mag;
    logic [VAL_W-1:0] dx;
    logic [VAL_W-1:0] w;
  } job_t;

endpackage

[rtl/plce_front.sv]
module plce_front #(
  parameter int NUM_KNOTS = plce_pkg::DEFAULT_NUM_KNOTS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [NUM_KNOTS-1:0][plce_pkg::KNOT_W-1:0] knots,
  input  logic                                       push,
  output logic                                       full,
  input  logic signed [plce_pkg::VAL_W-1:0]          x_value,
  output logic                                       job_push,
  output plce_pkg::job_t                             job,
  input  logic                                       job_full
);
  import plce_pkg::*;

  localparam int SEG_W = $clog2(NUM_KNOTS);
  localparam int LAST  = NUM_KNOTS - 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLASS,
    F_PREP
  } fstate_t;

  fstate_t            state;
  logic signed [VAL_W-1:0] x_reg;
  logic               direct;
  logic [SEG_W-1:0]   seg;

  logic signed [VAL_W-1:0] kx [NUM_KNOTS];
  logic signed [VAL_W-1:0] ky [NUM_KNOTS];
  logic [NUM_KNOTS-1:0]    lt;
  logic                    found;
  logic [SEG_W-1:0]        first_seg;
  logic [SEG_W-1:0]        seg_lo;
  logic signed [VAL_W:0]   dy;
  logic [VAL_W:0]          dy_abs;
  logic [VAL_W:0]          dx_full;
  logic [VAL_W:0]          w_full;

  always_comb begin
    for (int i = 0; i < NUM_KNOTS; i++) begin
      kx[i] = $signed(knots[i][KNOT_W-1:VAL_W]);
      ky[i] = $signed(knots[i][VAL_W-1:0]);
      lt[i] = x_reg < kx[i];
    end
  end

  // First knot above x, searching upward from knot 1
  always_comb begin
    found     = 1'b0;
    first_seg = '0;
    for (int i = 1; i < NUM_KNOTS; i++) begin
      if (!found && lt[i]) begin
        found     = 1'b1;
        first_seg = SEG_W'(i);
      end
    end
  end

  assign seg_lo  = seg - 1'b1;
  assign dy      = {ky[seg][VAL_W-1], ky[seg]} - {ky[seg_lo][VAL_W-1], ky[seg_lo]};
  assign dy_abs  = dy[VAL_W] ? (~dy + 1'b1) : dy;
  // Both are non-negative: the lower knot lies at or below x, the upper above it
  assign dx_full = {x_reg[VAL_W-1], x_reg} - {kx[seg_lo][VAL_W-1], kx[seg_lo]};
  assign w_full  = {kx[seg][VAL_W-1], kx[seg]} - {kx[seg_lo][VAL_W-1], kx[seg_lo]};

  always_comb begin
    job        = '0;
    job.direct = direct;
    if (direct) begin
      job.y0 = ky[seg];
    end else begin
      job.y0     = ky[seg_lo];
      job.neg    = dy[VAL_W];
      job.dy_mag = dy_abs[VAL_W-1:0];
      job.dx     = dx_full[VAL_W-1:0];
      job.w      = w_full[VAL_W-1:0];
    end
  end

  assign full     = (state != F_IDLE);
  assign job_push = (state == F_PREP) && !job_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      direct <= 1'b0;
      seg    <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            x_reg <= x_value;
            state <= F_CLASS;
          end
        end
        F_CLASS: begin
          if (lt[0]) begin
            direct <= 1'b1;
            seg    <= '0;
          end else if (!lt[LAST]) begin
            direct <= 1'b1;
            seg    <= SEG_W'(LAST);
          end else if (found) begin
            direct <= 1'b0;
            seg    <= first_seg;
          end else begin
            direct <= 1'b1;
            seg    <= '0;
          end
          state <= F_PREP;
        end
        F_PREP: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/plce_fifo.sv]
module plce_fifo #(
  parameter int DEPTH = plce_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  plce_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output plce_pkg::job_t rd_data,
  output logic           empty
);
  import plce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/plce_back.sv]
module plce_back (
  input  logic                       clk,
  input  logic                       rst,
  input  plce_pkg::job_t             job,
  input  logic                       job_empty,
  output logic                       job_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [plce_pkg::VAL_W-1:0] y_value
);
  import plce_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_FIN
  } bstate_t;

  bstate_t            state;
  job_t               cur;
  logic [VAL_W-1:0]   rem;
  logic [VAL_W-1:0]   qsh;
  logic [CNT_W-1:0]   count;
  logic               out_valid;

  logic [2*VAL_W-1:0] product;
  logic [VAL_W+1:0]   trial;
  logic               ge;
  logic [VAL_W-1:0]   sum;
  logic               slot_free;

  assign product = (2*VAL_W)'(cur.dy_mag) * (2*VAL_W)'(cur.dx);

  // Restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {1'b0, rem, qsh[VAL_W-1]} - {2'b00, cur.w};
  assign ge    = !trial[VAL_W+1];

  assign sum = cur.direct ? cur.y0 :
               cur.neg    ? cur.y0 - qsh : cur.y0 + qsh;

  assign slot_free = !out_valid || pop;
  assign job_pop   = (state == B_IDLE) && !job_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (state == B_FIN && slot_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!job_empty) begin
            cur   <= job;
            state <= job.direct ? B_FIN : B_MUL;
          end
        end
        B_MUL: begin
          // Upper half is below the divisor, so the quotient fits in 32 bits
          rem   <= product[2*VAL_W-1:VAL_W];
          qsh   <= product[VAL_W-1:0];
          count <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          rem   <= ge ? trial[VAL_W-1:0] : {rem[VAL_W-2:0], qsh[VAL_W-1]};
          qsh   <= {qsh[VAL_W-2:0], ge};
          count <= count + 1'b1;
          if (count == CNT_W'(VAL_W - 1)) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          if (slot_free) begin
            y_value <= sum;
            state   <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/piecewise_linear_curve_eval_core.sv]
// A clamped item passes the classify and prepare states, the job queue and the back end's
// finish state; an interpolated one also passes its multiply and divide states. The
// one-bit-a-cycle divider paces interpolated items and the classifier paces clamped ones.
// A two-entry queue between classifier and divider lets either side stall alone.
// Reset (synchronous, active high) clears all knots to zero and empties the block.
module piecewise_linear_curve_eval_core #(
  parameter int NUM_KNOTS = plce_pkg::DEFAULT_NUM_KNOTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plce_pkg::ADDR_W-1:0]       paddr,
  input  logic [plce_pkg::DATA_W-1:0]       pwdata,
  output logic [plce_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              push,
  output logic                              full,
  input  logic signed [plce_pkg::VAL_W-1:0] x_value,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [plce_pkg::VAL_W-1:0] y_value
);
  import plce_pkg::*;

  logic [NUM_KNOTS-1:0][KNOT_W-1:0] knots;
  logic [IDX_W-1:0]                 reg_idx;
  logic                             wr_en;

  job_t job_in;
  job_t job_out;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  logic [VAL_W-1:0] y_raw;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign wr_en   = psel && penable && pwrite;

  // Knots past the configured count are not stored; writes there drop
  always_ff @(posedge clk) begin
    if (rst) begin
      knots <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < NUM_KNOTS; i++) begin
        if (reg_idx == IDX_W'(i)) begin
          knots[i] <= pwdata[KNOT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_KNOTS; i++) begin
      if (reg_idx == IDX_W'(i)) begin
        prdata = DATA_W'(knots[i]);
      end
    end
  end

  plce_front #(
    .NUM_KNOTS (NUM_KNOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .knots    (knots),
    .push     (push),
    .full     (full),
    .x_value  (x_value),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  plce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  plce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .y_value   (y_raw)
  );

  assign y_value = $signed(y_raw);

endmodule
